// ===== sv/rsa_pkg.sv =====
// ============================================================================
// rsa_pkg: shared types and constants of the RGB saturation adjust unit
// Channel and pixel types, fixed-point widths and the constant-divide factors.
// ============================================================================
`timescale 1ns / 1ps

package rsa_pkg;

  // One color channel and one packed pixel (red in lane 0).
  typedef logic [7:0] chan_t;
  typedef logic [2:0][7:0] pix_t;

  // Pixels whose channel spread is at most this value pass unchanged.
  localparam chan_t PASS_SPREAD = 8'd25;

  // Gain in unsigned Q.16; the largest gain (setting 99) needs 23 bits.
  localparam int GAIN_W = 23;

  // Reciprocal of the spread, floor(2^32 / d), for d of at least 26.
  localparam int RCP_SHIFT = 32;
  localparam int RCP_W = 28;

  // floor(A * 8192 / 25) = A * DIV_MUL + floor(A * DIV_REM / 25).
  localparam int DIV_MUL = 8192 / 25;
  localparam int DIV_REM = 8192 % 25;
  localparam int DIV25_SHIFT = 26;
  localparam logic [21:0] DIV25_RCP = 22'((64'd1 << DIV25_SHIFT) / 25);

  // Lowest setting that always takes the gain from the pixel saturation.
  localparam logic [6:0] PCT_FULL = 7'd100;

endpackage

// ===== sv/rgb_saturation_adjust_unit.sv =====
// ============================================================================
// rgb_saturation_adjust_unit: HSL saturation adjustment of an RGB stream
// The unit takes one 8-bit RGB pixel per word and raises or lowers its HSL
// saturation by the signed percentage held in the configuration register.
// Pixels whose channel spread (max - min) is at most 25 leave unchanged and
// are flagged on out_tuser. All other pixels are pushed away from (positive
// setting) or pulled toward (negative setting) their lightness in unsigned
// Q.16 fixed point, truncated toward zero and clamped to 0..255. The unit
// takes one pixel every clock cycle while in_tready is high, and passes it
// through a six-register pipeline (spread, gain division and correction,
// two multiply stages and the output register). The gain division by the
// spread uses a reciprocal table and a one-step correction, and the
// division by 100 of the negative setting is a multiply by a constant
// reciprocal with the same correction.
// Every stage holds a valid bit, so a stalled output fills empty stages
// before in_tready drops, and no word is lost or repeated. The register is
// meant to be written while the pipeline is empty; it is read on the fly.
// ============================================================================
`timescale 1ns / 1ps

module rgb_saturation_adjust_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,    // saturation_percent, signed
  // Input pixel stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red_in [7:0], green_in [15:8], blue_in [23:16]
  // Result pixel stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic        out_tuser    // passed_through [0]
);

  localparam int NSTG = 6;

  // --------------------------------------------------------------------------
  // Constant tables. The spread reciprocal is indexed by the spread itself;
  // entries below 26 only serve pixels that pass through, so their value is unused.
  // The second table is pct / (100 - pct) in Q.16 for settings 0..99.
  // --------------------------------------------------------------------------
  logic [rsa_pkg::RCP_W-1:0]  rcp_tbl  [256];
  logic [rsa_pkg::GAIN_W-1:0] gain_tbl [128];

  for (genvar i = 0; i < 256; i++) begin : g_rcp
    localparam int unsigned DIV = (i < 26) ? 26 : i;
    localparam logic [rsa_pkg::RCP_W-1:0] RCP =
      rsa_pkg::RCP_W'((64'd1 << rsa_pkg::RCP_SHIFT) / DIV);
    assign rcp_tbl[i] = RCP;
  end

  for (genvar p = 0; p < 128; p++) begin : g_gain
    localparam int unsigned DEN = (p < 100) ? (100 - p) : 1;
    localparam logic [rsa_pkg::GAIN_W-1:0] GN =
      (p < 100) ? rsa_pkg::GAIN_W'((64'(p) << 16) / DEN) : '0;
    assign gain_tbl[p] = GN;
  end

  // --------------------------------------------------------------------------
  // Configuration register. Writes are always taken.
  // --------------------------------------------------------------------------
  logic [7:0] pct_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pct_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or when the stage after
  // it moves on, so bubbles close up while the output is stalled.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: channel max and min, spread d, sum s and saturation denominator.
  // --------------------------------------------------------------------------
  rsa_pkg::pix_t  in_px;
  rsa_pkg::chan_t s1_mx, s1_mn;
  rsa_pkg::chan_t s1_d_nxt, s1_den_nxt;
  logic [8:0]     s1_s_nxt;
  logic           s1_pass_nxt;

  rsa_pkg::pix_t  s1_c_r;
  rsa_pkg::chan_t s1_d_r, s1_den_r;
  logic [8:0]     s1_s_r;
  logic           s1_pass_r;

  always_comb begin
    in_px = in_tdata;
    s1_mx = in_px[0];
    s1_mn = in_px[0];
    for (int k = 1; k < 3; k++) begin
      if (in_px[k] > s1_mx) s1_mx = in_px[k];
      if (in_px[k] < s1_mn) s1_mn = in_px[k];
    end
    s1_d_nxt    = s1_mx - s1_mn;
    s1_s_nxt    = {1'b0, s1_mx} + {1'b0, s1_mn};
    s1_den_nxt  = (s1_s_nxt < 9'd255) ? s1_s_nxt[7:0] : 8'(10'd510 - {1'b0, s1_s_nxt});
    s1_pass_nxt = (s1_d_nxt <= rsa_pkg::PASS_SPREAD);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_c_r    <= in_px;
      s1_d_r    <= s1_d_nxt;
      s1_s_r    <= s1_s_nxt;
      s1_den_r  <= s1_den_nxt;
      s1_pass_r <= s1_pass_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the gain formula, estimate (den - d) / d in Q.16 through the
  // reciprocal table, look up the gain of the setting, and form 2c - s for
  // each channel together with the negative-setting factor 100 + pct.
  // --------------------------------------------------------------------------
  logic        s2_pos_nxt, s2_sel_nxt;
  logic [14:0] s2_lhs, s2_rhs;
  logic [6:0]  s2_cmp_pct;
  logic [35:0] s2_qprod;
  logic [8:0]  s2_f;
  logic [9:0]  s2_e_nxt [3];
  logic [7:0]  s2_nn_nxt;
  logic [6:0]  s2_fmag_nxt;
  logic        s2_fneg_nxt;

  rsa_pkg::pix_t               s2_c_r;
  logic [8:0]                  s2_s_r;
  rsa_pkg::chan_t              s2_d_r;
  logic                        s2_pass_r, s2_pos_r, s2_sel_r;
  logic [19:0]                 s2_qd0_r;
  logic [7:0]                  s2_nn_r;
  logic [rsa_pkg::GAIN_W-1:0]  s2_g2_r;
  logic [9:0]                  s2_e_r [3];
  logic [6:0]                  s2_fmag_r;
  logic                        s2_fneg_r;

  always_comb begin
    s2_pos_nxt  = !pct_r[7];
    s2_cmp_pct  = rsa_pkg::PCT_FULL - pct_r[6:0];
    s2_lhs      = 15'(s1_d_r * 7'd100);
    s2_rhs      = 15'(s2_cmp_pct * s1_den_r);
    s2_sel_nxt  = (pct_r[6:0] >= rsa_pkg::PCT_FULL) || (s2_lhs >= s2_rhs);
    s2_nn_nxt   = s1_den_r - s1_d_r;
    s2_qprod    = s2_nn_nxt * rcp_tbl[s1_d_r];
    for (int k = 0; k < 3; k++) begin
      s2_e_nxt[k] = {1'b0, s1_c_r[k], 1'b0} - {1'b0, s1_s_r};
    end
    s2_f        = {pct_r[7], pct_r} + 9'd100;
    s2_fneg_nxt = s2_f[8];
    s2_fmag_nxt = 7'(s2_fneg_nxt ? (9'd0 - s2_f) : s2_f);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_c_r    <= s1_c_r;
      s2_s_r    <= s1_s_r;
      s2_d_r    <= s1_d_r;
      s2_pass_r <= s1_pass_r;
      s2_pos_r  <= s2_pos_nxt;
      s2_sel_r  <= s2_sel_nxt;
      s2_qd0_r  <= s2_qprod[35:16];
      s2_nn_r   <= s2_nn_nxt;
      s2_g2_r   <= gain_tbl[pct_r[6:0]];
      s2_e_r    <= s2_e_nxt;
      s2_fmag_r <= s2_fmag_nxt;
      s2_fneg_r <= s2_fneg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the reciprocal estimate is exact or one low; one remainder check
  // fixes it. The negative path forms |2c - s| * |100 + pct| per channel.
  // --------------------------------------------------------------------------
  logic [27:0]                 s3_num, s3_dq, s3_rem;
  logic [19:0]                 s3_g1;
  logic [rsa_pkg::GAIN_W-1:0]  s3_gain_nxt;
  logic [8:0]                  s3_emag [3];
  logic [15:0]                 s3_amag_nxt [3];
  logic [2:0]                  s3_aneg_nxt;

  rsa_pkg::pix_t               s3_c_r;
  logic [8:0]                  s3_s_r;
  logic                        s3_pass_r, s3_pos_r;
  logic [rsa_pkg::GAIN_W-1:0]  s3_gain_r;
  logic [9:0]                  s3_e_r [3];
  logic [15:0]                 s3_amag_r [3];
  logic [2:0]                  s3_aneg_r;

  always_comb begin
    s3_num      = {4'd0, s2_nn_r, 16'd0};
    s3_dq       = s2_qd0_r * s2_d_r;
    s3_rem      = s3_num - s3_dq;
    s3_g1       = s2_qd0_r + 20'(s3_rem >= {20'd0, s2_d_r});
    s3_gain_nxt = s2_sel_r ? rsa_pkg::GAIN_W'(s3_g1) : s2_g2_r;
    for (int k = 0; k < 3; k++) begin
      s3_emag[k]     = 9'(s2_e_r[k][9] ? (10'd0 - s2_e_r[k]) : s2_e_r[k]);
      s3_amag_nxt[k] = 16'(s3_emag[k] * s2_fmag_r);
      s3_aneg_nxt[k] = s2_e_r[k][9] ^ s2_fneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_c_r    <= s2_c_r;
      s3_s_r    <= s2_s_r;
      s3_pass_r <= s2_pass_r;
      s3_pos_r  <= s2_pos_r;
      s3_gain_r <= s3_gain_nxt;
      s3_e_r    <= s2_e_r;
      s3_amag_r <= s3_amag_nxt;
      s3_aneg_r <= s3_aneg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: positive path multiplies (2c - s) by the gain; negative path
  // estimates floor(17 * A / 25) through the reciprocal of 25.
  // --------------------------------------------------------------------------
  logic signed [33:0] s4_p_nxt [3];
  logic [19:0]        s4_t_nxt [3];
  logic [41:0]        s4_qprod [3];

  rsa_pkg::pix_t      s4_c_r;
  logic [8:0]         s4_s_r;
  logic               s4_pass_r, s4_pos_r;
  logic signed [33:0] s4_p_r [3];
  logic [19:0]        s4_t_r [3];
  logic [15:0]        s4_q0_r [3];
  logic [15:0]        s4_amag_r [3];
  logic [2:0]         s4_aneg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_p_nxt[k] = $signed(s3_e_r[k]) * $signed({1'b0, s3_gain_r});
      s4_t_nxt[k] = 20'(s3_amag_r[k] * rsa_pkg::DIV_REM);
      s4_qprod[k] = s4_t_nxt[k] * rsa_pkg::DIV25_RCP;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_c_r    <= s3_c_r;
      s4_s_r    <= s3_s_r;
      s4_pass_r <= s3_pass_r;
      s4_pos_r  <= s3_pos_r;
      s4_p_r    <= s4_p_nxt;
      s4_t_r    <= s4_t_nxt;
      for (int k = 0; k < 3; k++) begin
        s4_q0_r[k] <= s4_qprod[k][41:26];
      end
      s4_amag_r <= s3_amag_r;
      s4_aneg_r <= s3_aneg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: positive result c + trunc(P / 2), truncated and clamped. The
  // negative path corrects its quotient and completes A * 8192 / 25.
  // --------------------------------------------------------------------------
  logic signed [33:0] s5_h [3];
  logic signed [34:0] s5_v [3];
  rsa_pkg::pix_t      s5_rpos_nxt;
  logic [19:0]        s5_rem [3];
  logic [15:0]        s5_qq [3];
  logic [24:0]        s5_quot_nxt [3];

  rsa_pkg::pix_t      s5_c_r;
  logic [8:0]         s5_s_r;
  logic               s5_pass_r, s5_pos_r;
  rsa_pkg::pix_t      s5_rpos_r;
  logic [24:0]        s5_quot_r [3];
  logic [2:0]         s5_aneg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // Halving rounds toward zero, as the Q.16 product does.
      s5_h[k] = s4_p_r[k][33] ? ((s4_p_r[k] + 34'sd1) >>> 1) : (s4_p_r[k] >>> 1);
      s5_v[k] = $signed({3'd0, s4_c_r[k], 16'd0}) + 35'(s5_h[k]);
      if (s5_v[k] < 0) begin
        s5_rpos_nxt[k] = 8'd0;
      end else if (s5_v[k][34:24] != 11'd0) begin
        s5_rpos_nxt[k] = 8'd255;
      end else begin
        s5_rpos_nxt[k] = s5_v[k][23:16];
      end
      s5_rem[k]      = s4_t_r[k] - 20'(s4_q0_r[k] * 5'd25);
      s5_qq[k]       = s4_q0_r[k] + 16'(s5_rem[k] >= 20'd25);
      s5_quot_nxt[k] = 25'(s4_amag_r[k] * rsa_pkg::DIV_MUL) + 25'(s5_qq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_c_r    <= s4_c_r;
      s5_s_r    <= s4_s_r;
      s5_pass_r <= s4_pass_r;
      s5_pos_r  <= s4_pos_r;
      s5_rpos_r <= s5_rpos_nxt;
      s5_quot_r <= s5_quot_nxt;
      s5_aneg_r <= s4_aneg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6 (output register): negative result L + prod, clamped, and the
  // final choice between pass-through, positive and negative results.
  // --------------------------------------------------------------------------
  logic signed [26:0] s6_v [3];
  rsa_pkg::pix_t      s6_rneg;
  rsa_pkg::pix_t      out_px_nxt;
  rsa_pkg::pix_t      out_px_r;
  logic               out_pass_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s6_v[k] = s5_aneg_r[k]
                ? ($signed({3'd0, s5_s_r, 15'd0}) - $signed({2'd0, s5_quot_r[k]}))
                : ($signed({3'd0, s5_s_r, 15'd0}) + $signed({2'd0, s5_quot_r[k]}));
      if (s6_v[k] < 0) begin
        s6_rneg[k] = 8'd0;
      end else if (s6_v[k][26:24] != 3'd0) begin
        s6_rneg[k] = 8'd255;
      end else begin
        s6_rneg[k] = s6_v[k][23:16];
      end
    end
    if (s5_pass_r) begin
      out_px_nxt = s5_c_r;
    end else if (s5_pos_r) begin
      out_px_nxt = s5_rpos_r;
    end else begin
      out_px_nxt = s6_rneg;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_px_r   <= out_px_nxt;
      out_pass_r <= s5_pass_r;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = out_px_r;
  assign out_tuser  = out_pass_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  rsa_pkg::chan_t chk_mx, chk_mn;

  always_comb begin
    chk_mx = out_px_r[0];
    chk_mn = out_px_r[0];
    for (int k = 1; k < 3; k++) begin
      if (out_px_r[k] > chk_mx) chk_mx = out_px_r[k];
      if (out_px_r[k] < chk_mn) chk_mn = out_px_r[k];
    end
  end

  // The first stage only fills from an accepted input word.
  a_fill_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[0]) |-> $past(in_tvalid && in_tready))
    else $error("stage 1 filled without an accepted input word");

  // Input back-pressure only when every stage holds a word.
  a_no_stall_with_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled while a pipeline stage is empty");

  // A passed-through result keeps a spread within the pass limit.
  a_pass_spread: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((chk_mx - chk_mn) <= rsa_pkg::PASS_SPREAD))
    else $error("passed-through pixel has a spread above the limit");

endmodule

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top: self-checking testbench of the RGB saturation adjust unit
// Drives pixel words through the unit under a series of saturation settings.
// Each accepted pixel is run through a local fixed-point model of the
// adjustment, and every result word is compared against the oldest pending
// pixel. A directed table comes first, then random pixels under changing
// settings and changing backpressure.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRESSURE_HOLD = 80;
  localparam int PHASE_PIXELS = 80;
  localparam int NUM_PHASES = 12;
  localparam int NUM_DIRECTED = 24;

  typedef struct packed {
    rsa_pkg::chan_t red;
    rsa_pkg::chan_t green;
    rsa_pkg::chan_t blue;
    logic           passed;
  } pixel_res_t;

  typedef struct packed {
    logic signed [7:0] setting;
    rsa_pkg::chan_t    red;
    rsa_pkg::chan_t    green;
    rsa_pkg::chan_t    blue;
    logic              typed;
    pixel_res_t        want;
  } dir_row_t;

  // Rows with typed = 1 carry a result that is obvious by inspection; the
  // others are left to the local model.
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{8'sd0, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{8'sd0, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{8'sd0, 8'd25, 8'd0, 8'd0, 1'b1, '{8'd25, 8'd0, 8'd0, 1'b1}},
    '{8'sd0, 8'd26, 8'd0, 8'd0, 1'b1, '{8'd26, 8'd0, 8'd0, 1'b0}},
    '{8'sd0, 8'd255, 8'd0, 8'd128, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b0}},
    '{8'sd0, 8'd10, 8'd200, 8'd90, 1'b1, '{8'd10, 8'd200, 8'd90, 1'b0}},
    '{8'sd100, 8'd255, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}},
    '{8'sd100, 8'd200, 8'd100, 8'd100, 1'b0, '0},
    '{8'sd100, 8'd60, 8'd30, 8'd40, 1'b0, '0},
    '{8'sd100, 8'd130, 8'd100, 8'd155, 1'b0, '0},
    '{8'sd100, 8'd127, 8'd127, 8'd101, 1'b0, '0},
    '{8'sd127, 8'd200, 8'd100, 8'd100, 1'b0, '0},
    '{8'sd127, 8'd240, 8'd30, 8'd220, 1'b0, '0},
    '{-8'sd100, 8'd255, 8'd0, 8'd0, 1'b1, '{8'd127, 8'd127, 8'd127, 1'b0}},
    '{-8'sd100, 8'd200, 8'd100, 8'd50, 1'b1, '{8'd125, 8'd125, 8'd125, 1'b0}},
    '{-8'sd100, 8'd20, 8'd20, 8'd20, 1'b1, '{8'd20, 8'd20, 8'd20, 1'b1}},
    '{-8'sd128, 8'd255, 8'd0, 8'd0, 1'b0, '0},
    '{-8'sd128, 8'd0, 8'd255, 8'd255, 1'b0, '0},
    '{8'sd50, 8'd140, 8'd100, 8'd120, 1'b0, '0},
    '{8'sd50, 8'd250, 8'd10, 8'd5, 1'b0, '0},
    '{-8'sd50, 8'd200, 8'd40, 8'd90, 1'b0, '0},
    '{-8'sd50, 8'd255, 8'd255, 8'd0, 1'b0, '0},
    '{8'sd99, 8'd100, 8'd60, 8'd80, 1'b0, '0},
    '{8'sd99, 8'd128, 8'd127, 8'd0, 1'b0, '0}
  };

  typedef struct {
    int         seq;
    pixel_res_t res;
  } fixed_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  pixel_res_t        expected_pixels [$];
  fixed_result_t     fixed_results [$];
  logic signed [7:0] pct_setting = 8'sd0;
  int                accepted_pixels = 0;
  int                sent_pixels = 0;
  int                passed_pixels = 0;
  int                settings_written = 0;
  int                input_stall_cycles = 0;
  int                error_count = 0;
  int                idle_cycles = 0;
  int                gap_pct = 0;
  int                stall_pct = 0;
  bit                hold_req = 1'b0;

  rgb_saturation_adjust_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Converts a Q.16 channel to an integer, truncating toward zero, and
  // clamps it to the byte range.
  function automatic rsa_pkg::chan_t clamp_channel(input longint q);
    longint v;
    v = q / 65536;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return rsa_pkg::chan_t'(v);
  endfunction

  function automatic pixel_res_t adjust_saturation(input rsa_pkg::chan_t red,
                                                   input rsa_pkg::chan_t green,
                                                   input rsa_pkg::chan_t blue,
                                                   input logic signed [7:0] pct_reg);
    longint         chan [3];
    longint         mx, mn, spread, sum, den, pct, lq, gain, cq, prod;
    rsa_pkg::chan_t adj [3];
    pixel_res_t     res;
    chan[0] = longint'(red);
    chan[1] = longint'(green);
    chan[2] = longint'(blue);
    mx = chan[0];
    mn = chan[0];
    for (int k = 1; k < 3; k++) begin
      if (chan[k] > mx) mx = chan[k];
      if (chan[k] < mn) mn = chan[k];
    end
    spread = mx - mn;
    sum = mx + mn;
    if (spread <= longint'(rsa_pkg::PASS_SPREAD)) begin
      res = '{red, green, blue, 1'b1};
      return res;
    end
    pct = longint'(pct_reg);
    den = (sum < 255) ? sum : 510 - sum;
    lq = sum * 32768;
    if (pct >= 0) begin
      // The gain comes from the pixel's own saturation once it is high
      // enough for the setting, otherwise from the setting alone.
      if (100 * spread >= (100 - pct) * den)
        gain = ((den - spread) * 65536) / spread;
      else
        gain = (pct * 65536) / (100 - pct);
      for (int k = 0; k < 3; k++) begin
        cq = chan[k] * 65536;
        prod = ((cq - lq) * gain) / 65536;
        adj[k] = clamp_channel(cq + prod);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        cq = chan[k] * 65536;
        prod = ((cq - lq) * (100 + pct)) / 100;
        adj[k] = clamp_channel(lq + prod);
      end
    end
    res = '{adj[0], adj[1], adj[2], 1'b0};
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Mixes plain random pixels with near-gray ones around the pass-through
  // threshold, ones whose max + min sits at or next to 255, and ones built from extremes.
  function automatic logic [23:0] random_pixel();
    rsa_pkg::chan_t c [3];
    int             base, mn, mx, i, j;
    case ($urandom_range(9))
      0, 1, 2, 3: return 24'($urandom);
      4, 5: begin
        base = $urandom_range(225);
        for (int k = 0; k < 3; k++) c[k] = rsa_pkg::chan_t'(base + $urandom_range(30));
      end
      6, 7: begin
        mn = $urandom_range(127);
        mx = 255 - mn + $urandom_range(2) - 1;
        if (mx > 255) mx = 255;
        for (int k = 0; k < 3; k++) c[k] = rsa_pkg::chan_t'($urandom_range(mx, mn));
        i = $urandom_range(2);
        j = (i + $urandom_range(2, 1)) % 3;
        c[i] = rsa_pkg::chan_t'(mx);
        c[j] = rsa_pkg::chan_t'(mn);
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          case ($urandom_range(4))
            0: c[k] = 8'd0;
            1: c[k] = 8'd255;
            2: c[k] = 8'd1;
            3: c[k] = 8'd254;
            default: c[k] = rsa_pkg::chan_t'($urandom);
          endcase
        end
      end
    endcase
    return {c[2], c[1], c[0]};
  endfunction

  task automatic send_pixel(input logic [23:0] pixel);
    in_tvalid <= 1'b1;
    in_tdata <= pixel;
    do @(posedge clk); while (!in_tready);
    sent_pixels++;
  endtask

  // Each cycle the sender stays idle with the phase's gap percentage.
  task automatic idle_sender();
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every pixel in flight has come back, then lets the pipeline
  // settle before the register may be touched.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_setting(input logic signed [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checking and prediction, both sampled at the clock edge.
  always @(posedge clk) begin : result_check
    pixel_res_t    got;
    pixel_res_t    want;
    fixed_result_t fixed;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        pct_setting = cfg_data;
        settings_written++;
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser};
        if (expected_pixels.size() == 0) begin
          $error("result word arrived with no pixel outstanding");
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
          check_field("passed_through", want.passed, got.passed);
        end
      end
      if (in_tvalid && in_tready) begin
        want = adjust_saturation(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], pct_setting);
        if (fixed_results.size() != 0 && fixed_results[0].seq == accepted_pixels) begin
          fixed = fixed_results.pop_front();
          want = fixed.res;
        end
        expected_pixels.insert(expected_pixels.size(), want);
        accepted_pixels++;
        if (want.passed) passed_pixels++;
      end
      if (in_tvalid && !in_tready) input_stall_cycles++;
    end
  end

  // Watchdog: ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic signed [7:0] cur_setting;
    logic signed [7:0] phase_setting [NUM_PHASES];
    phase_setting = '{8'sd127, -8'sd128, 8'sd100, -8'sd100, 8'sd0, 8'sd50,
                      -8'sd50, 8'sd99, -8'sd99, 8'sd1, -8'sd1, 8'sd0};
    phase_setting[NUM_PHASES - 1] = 8'($urandom_range(255));
    cur_setting = 8'sd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, run at full rate; the register holds zero after reset.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED[r].setting != cur_setting) begin
        drain();
        write_setting(DIRECTED[r].setting);
        cur_setting = DIRECTED[r].setting;
      end
      if (DIRECTED[r].typed)
        fixed_results.insert(fixed_results.size(),
                             '{seq: sent_pixels, res: DIRECTED[r].want});
      send_pixel({DIRECTED[r].blue, DIRECTED[r].green, DIRECTED[r].red});
    end

    // Random phases, each under its own setting and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_setting(phase_setting[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      // One phase at full input rate starts with a long output hold-off so
      // the pipeline fills and the input backs up.
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(random_pixel());
        idle_sender();
      end
    end

    drain();
    repeat (4 * LATENCY) @(posedge clk);
    $display("Covered %0d pixels (%0d passed through) under %0d register writes.",
             accepted_pixels, passed_pixels, settings_written);
    $display("Input was held back by the output for %0d cycles.", input_stall_cycles);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
